### rtl/rau_pkg.sv
// rational arithmetic unit package: widths, action codes, sequencer states, divider status
`default_nettype none

package rau_pkg;

    // fixed widths of the payload
    localparam int ACT_W             = 3;
    localparam int RES_W             = 33;
    localparam int OPERAND_WIDTH_DEF = 16;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RED = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_GCD_CHK,
        ST_GCD_WAIT,
        ST_QN_WAIT,
        ST_QD_WAIT,
        ST_OUT
    } t_state;

    // status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage : rau_pkg

`default_nettype wire

### rtl/rau_in_if.sv
// input channel: action code and two signed fractions
`default_nettype none

interface rau_in_if #(
    parameter int W = rau_pkg::OPERAND_WIDTH_DEF
);
    import rau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic signed [W-1:0]     a_num;
    logic signed [W-1:0]     a_den;
    logic signed [W-1:0]     b_num;
    logic signed [W-1:0]     b_den;

    modport source (output valid, output action, output a_num, output a_den,
                    output b_num, output b_den, input ready);
    modport sink   (input valid, input action, input a_num, input a_den,
                    input b_num, input b_den, output ready);
endinterface : rau_in_if

`default_nettype wire

### rtl/rau_out_if.sv
// output channel: result fraction and error flag
`default_nettype none

interface rau_out_if;
    import rau_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    error;

    modport source (output valid, output res_num, output res_den, output error,
                    input ready);
    modport sink   (input valid, input res_num, input res_den, input error,
                    output ready);
endinterface : rau_out_if

`default_nettype wire

### rtl/rau_div.sv
// shared iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rau_div #(
    parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W-1:0]      i_dividend,
    input  wire logic [W-1:0]      i_divisor,
    output rau_pkg::t_div_stat     o_stat,
    output logic [W-1:0]           o_quo,
    output logic [W-1:0]           o_rem
);
    import rau_pkg::*;

    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]       rem_sh;
    logic [W:0]       diff;

    // trial subtraction of the shifted partial remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
    end

    // control: bit counter and busy/done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_LOAD;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_LAST;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient shifts in from the dividend side
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule : rau_div

`default_nettype wire

### rtl/rational_arithmetic_unit.sv
// rational arithmetic unit top level: sequencer, shared multiplier and divider
// Usage:
//   i_in carries an action code and two signed fractions a_num/a_den, b_num/b_den;
//   o_out returns one result item res_num/res_den with an error flag per input item.
//   The block holds one item at a time: i_in.ready is high only while it is idle.
// Operation:
//   add, subtract, multiply, divide: states ST_MUL0 to ST_MUL3, then o_out.valid, using
//   one signed multiplier over three product slots and an accumulate.
//   reduce: a chain of Euclidean remainder steps, then two final quotients for the
//   numerator and denominator; each step and each of the two final quotients is
//   one pass of the bit-serial divider over OPERAND_WIDTH quotient bits.
//   Undefined actions give a zero result in the cycle after acceptance.
// Items: a new item is taken only after the result of the last has been handed over.
// Reset: synchronous, active low; returns the sequencer and divider to idle and
//   drops any item in flight.
// Stall: the result stays in the output register with o_out.valid high until
//   o_out.ready; no new item is taken before it has gone.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int EW = (PW > RES_W) ? PW : RES_W;
    localparam logic [W-1:0]     ONE_W   = {{(W-1){1'b0}}, 1'b1};
    localparam logic [RES_W-1:0] ONE_RES = {{(RES_W-1){1'b0}}, 1'b1};

    t_state r_state, n_state;

    // item registers
    logic [ACT_W-1:0]    r_act;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]        r_man, r_mad;

    // euclid pair, magnitudes with separate signs
    logic [W-1:0]        r_x, r_y;
    logic                r_sx, r_sy;

    // product and result registers
    logic [RES_W-1:0]    r_prod;
    logic [RES_W-1:0]    r_num, r_den;
    logic                r_err;

    // shared units
    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    logic signed [EW-1:0] mul_ext;
    logic [RES_W-1:0]     prod_res;

    logic                 div_start;
    logic [W-1:0]         div_dvd, div_dsr, div_quo, div_rem;
    t_div_stat            div_stat;

    logic                 in_acc;
    logic [W-1:0]         in_man, in_mad;
    logic [RES_W-1:0]     quo_res;

    rau_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // multiplier and wrap to the result width
    always_comb begin
        mul_p    = mul_x * mul_y;
        mul_ext  = EW'(mul_p);
        prod_res = mul_ext[RES_W-1:0];
    end

    // input magnitudes and quotient widened to the result
    always_comb begin
        in_acc  = i_in.valid && i_in.ready;
        in_man  = i_in.a_num[W-1] ? (~$unsigned(i_in.a_num) + ONE_W) : $unsigned(i_in.a_num);
        in_mad  = i_in.a_den[W-1] ? (~$unsigned(i_in.a_den) + ONE_W) : $unsigned(i_in.a_den);
        quo_res = {{(RES_W-W){1'b0}}, div_quo};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.action == ACT_RED) begin
                        n_state = ST_GCD_CHK;
                    end else if (i_in.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV}) begin
                        n_state = ST_MUL0;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_OUT;
            ST_GCD_CHK: begin
                if (r_y != '0) begin
                    n_state = ST_GCD_WAIT;
                end else if (r_x == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_QN_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (div_stat.done) n_state = ST_GCD_CHK;
            end
            ST_QN_WAIT: begin
                if (div_stat.done) n_state = ST_QD_WAIT;
            end
            ST_QD_WAIT: begin
                if (div_stat.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshakes, multiplier operands, divider requests
    always_comb begin
        i_in.ready = 1'b0;
        o_out.valid = 1'b0;
        mul_x = '0;
        mul_y = '0;
        div_start = 1'b0;
        div_dvd = r_x;
        div_dsr = r_y;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_MUL0: begin
                mul_x = r_an;
                mul_y = (r_act == ACT_MUL) ? r_bn : r_bd;
            end
            ST_MUL1: begin
                if (r_act inside {ACT_ADD, ACT_SUB}) begin
                    mul_x = r_bn;
                    mul_y = r_ad;
                end
            end
            ST_MUL2: begin
                mul_x = r_ad;
                mul_y = (r_act == ACT_DIV) ? r_bn : r_bd;
            end
            ST_GCD_CHK: begin
                if (r_y != '0) begin
                    div_start = 1'b1;
                end else if (r_x != '0) begin
                    div_start = 1'b1;
                    div_dvd   = r_man;
                    div_dsr   = r_x;
                end
            end
            ST_QN_WAIT: begin
                if (div_stat.done) begin
                    div_start = 1'b1;
                    div_dvd   = r_mad;
                    div_dsr   = r_x;
                end
            end
            ST_OUT: o_out.valid = 1'b1;
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_act <= i_in.action;
                    r_an  <= i_in.a_num;
                    r_ad  <= i_in.a_den;
                    r_bn  <= i_in.b_num;
                    r_bd  <= i_in.b_den;
                    r_man <= in_man;
                    r_mad <= in_mad;
                    r_x   <= in_man;
                    r_sx  <= i_in.a_num[W-1];
                    r_y   <= in_mad;
                    r_sy  <= i_in.a_den[W-1];
                    r_num <= '0;
                    r_den <= '0;
                    r_err <= 1'b0;
                end
            end
            ST_MUL0: r_prod <= prod_res;
            ST_MUL1: begin
                r_num  <= r_prod;
                r_prod <= prod_res;
            end
            ST_MUL2: begin
                r_num  <= (r_act == ACT_SUB) ? (r_num - r_prod) : (r_num + r_prod);
                r_prod <= prod_res;
            end
            ST_MUL3: begin
                r_den <= r_prod;
                r_err <= (r_act == ACT_DIV) && ((r_ad == '0) || (r_bn == '0));
            end
            ST_GCD_CHK: begin
                // gcd of zero: pass the operands through and flag
                if ((r_y == '0) && (r_x == '0)) begin
                    r_num <= RES_W'(r_an);
                    r_den <= RES_W'(r_ad);
                    r_err <= 1'b1;
                end
            end
            ST_GCD_WAIT: begin
                // remainder keeps the sign of the dividend
                if (div_stat.done) begin
                    r_x  <= r_y;
                    r_sx <= r_sy;
                    r_y  <= div_rem;
                    r_sy <= r_sx;
                end
            end
            ST_QN_WAIT: begin
                if (div_stat.done) begin
                    r_num <= (r_an[W-1] ^ r_sx) ? (~quo_res + ONE_RES) : quo_res;
                end
            end
            ST_QD_WAIT: begin
                if (div_stat.done) begin
                    r_den <= (r_ad[W-1] ^ r_sx) ? (~quo_res + ONE_RES) : quo_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out.res_num = r_num;
    assign o_out.res_den = r_den;
    assign o_out.error   = r_err;

    // checks on the sequencer and the shared divider
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD_WAIT) |-> (r_y != '0))
        else $error("remainder step with zero divisor");

    a_err_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error) |-> ((r_act == ACT_DIV) || (r_act == ACT_RED)))
        else $error("error flag on an action that cannot raise it");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(r_num) && $stable(r_den)))
        else $error("result changed while stalled");

endmodule : rational_arithmetic_unit

`default_nettype wire

### verif/rational_arithmetic_unit_test.sv
// testbench for the rational arithmetic unit: directed table, random items, result check
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam int OPW        = OPERAND_WIDTH_DEF;
    localparam int RAND_ITEMS = 900;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYC  = 60;

    localparam logic signed [OPW-1:0] OP_MIN = {1'b1, {(OPW-1){1'b0}}};
    localparam logic signed [OPW-1:0] OP_MAX = {1'b0, {(OPW-1){1'b1}}};

    // codes the block does not define, expected to give a zero result
    localparam logic [ACT_W-1:0] ACT_RSV5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSV6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSV7 = 3'd7;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic signed [OPW-1:0] an;
        logic signed [OPW-1:0] ad;
        logic signed [OPW-1:0] bn;
        logic signed [OPW-1:0] bd;
    } t_item;

    typedef struct packed {
        logic signed [RES_W-1:0] num;
        logic signed [RES_W-1:0] den;
        logic                    err;
    } t_fraction;

    typedef struct {
        t_item     item;
        bit        known;
        t_fraction want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    rau_in_if #(.W(OPW)) in_ch ();
    rau_out_if           out_ch ();

    rational_arithmetic_unit #(
        .OPERAND_WIDTH(OPW)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_fraction pending_results[$];
    t_row      directed_rows[$];
    int        fail_count   = 0;
    int        results_seen = 0;
    int        burst_left   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gcd by repeated truncating remainder, sign as it falls out of the loop
    function automatic longint trunc_gcd(longint x, longint y);
        longint t;
        while (y != 0) begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    // expected result fraction for one item
    function automatic t_fraction fraction_op(t_item it);
        longint    an, ad, bn, bd, g, rn, rd;
        t_fraction r;
        an = $signed(it.an);
        ad = $signed(it.ad);
        bn = $signed(it.bn);
        bd = $signed(it.bd);
        rn = 0;
        rd = 0;
        r.err = 1'b0;
        case (it.act)
            ACT_ADD: begin
                rn = an * bd + bn * ad;
                rd = ad * bd;
            end
            ACT_SUB: begin
                rn = an * bd - bn * ad;
                rd = ad * bd;
            end
            ACT_MUL: begin
                rn = an * bn;
                rd = ad * bd;
            end
            ACT_DIV: begin
                rn = an * bd;
                rd = ad * bn;
                r.err = (rd == 0);
            end
            ACT_RED: begin
                g = trunc_gcd(an, ad);
                if (g == 0) begin
                    rn = an;
                    rd = ad;
                    r.err = 1'b1;
                end else begin
                    rn = an / g;
                    rd = ad / g;
                end
            end
            default: ;
        endcase
        r.num = rn[RES_W-1:0];
        r.den = rd[RES_W-1:0];
        return r;
    endfunction

    // directed table entry; known rows carry their result typed in
    task automatic table_row(input logic [ACT_W-1:0] act, input logic signed [OPW-1:0] an,
                             input logic signed [OPW-1:0] ad, input logic signed [OPW-1:0] bn,
                             input logic signed [OPW-1:0] bd, input bit known,
                             input longint num, input longint den, input bit err);
        t_row row;
        row.item      = '{act: act, an: an, ad: ad, bn: bn, bd: bd};
        row.known     = known;
        row.want.num  = num[RES_W-1:0];
        row.want.den  = den[RES_W-1:0];
        row.want.err  = err;
        directed_rows.push_back(row);
    endtask

    function automatic logic signed [OPW-1:0] random_operand();
        int          v;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return OP_MIN;
                    1:       return OP_MAX;
                    2:       return '1;
                    default: return 1;
                endcase
            end
            2, 3: begin
                v = int'($urandom_range(0, 40)) - 20;
                return v[OPW-1:0];
            end
            default: return r[OPW-1:0];
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    sel, k, x, y;
        sel = $urandom_range(0, 19);
        it.an = random_operand();
        it.ad = random_operand();
        it.bn = random_operand();
        it.bd = random_operand();
        if (sel < 4)
            it.act = ACT_ADD;
        else if (sel < 7)
            it.act = ACT_SUB;
        else if (sel < 10)
            it.act = ACT_MUL;
        else if (sel < 14)
            it.act = ACT_DIV;
        else if (sel < 19) begin
            it.act = ACT_RED;
            // half the reductions get a common factor so the gcd is not trivial
            if ($urandom_range(0, 1) == 1) begin
                k = $urandom_range(1, 200);
                x = int'($urandom_range(0, 300)) - 150;
                y = int'($urandom_range(0, 300)) - 150;
                x = k * x;
                y = k * y;
                it.an = x[OPW-1:0];
                it.ad = y[OPW-1:0];
            end
        end else begin
            case ($urandom_range(0, 2))
                0:       it.act = ACT_RSV5;
                1:       it.act = ACT_RSV6;
                default: it.act = ACT_RSV7;
            endcase
        end
        return it;
    endfunction

    // offer one item in bursts with random gaps, record its result once accepted
    task automatic offer_item(input t_item it, input t_fraction want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid  <= 1'b1;
        in_ch.action <= it.act;
        in_ch.a_num  <= it.an;
        in_ch.a_den  <= it.ad;
        in_ch.b_num  <= it.bn;
        in_ch.b_den  <= it.bd;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        t_item it;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.action = '0;
        in_ch.a_num  = '0;
        in_ch.a_den  = '0;
        in_ch.b_num  = '0;
        in_ch.b_den  = '0;
        out_ch.ready = 1'b0;

        // extremes, zero denominators, every action and reduce corner
        table_row(ACT_ADD, 0, 1, 0, 1, 1, 0, 1, 0);
        table_row(ACT_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1, 64'd2147483648, 64'd1073741824, 0);
        table_row(ACT_ADD, 1, 0, 1, 0, 1, 0, 0, 0);
        table_row(ACT_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX, 0, 0, 0, 0);
        table_row(ACT_SUB, 7, 1, 7, 1, 1, 0, 1, 0);
        table_row(ACT_SUB, OP_MAX, OP_MIN, OP_MIN, OP_MAX, 0, 0, 0, 0);
        table_row(ACT_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1, 64'd1073741824, 64'd1073741824, 0);
        table_row(ACT_MUL, 3, 0, 5, 0, 1, 15, 0, 0);
        table_row(ACT_MUL, OP_MIN, OP_MAX, OP_MAX, OP_MIN, 0, 0, 0, 0);
        table_row(ACT_DIV, 1, 2, 0, 3, 1, 3, 0, 1);
        table_row(ACT_DIV, 5, 0, 7, 1, 1, 5, 0, 1);
        table_row(ACT_DIV, OP_MAX, 1, 1, OP_MIN, 0, 0, 0, 0);
        table_row(ACT_RED, 0, 0, 9, 9, 1, 0, 0, 1);
        table_row(ACT_RED, 6, 4, 0, 0, 1, 3, 2, 0);
        table_row(ACT_RED, -6, 4, 0, 0, 0, 0, 0, 0);
        table_row(ACT_RED, 0, 5, 1, 1, 1, 0, 1, 0);
        table_row(ACT_RED, 5, 0, 1, 1, 1, 1, 0, 0);
        table_row(ACT_RED, OP_MIN, OP_MIN, OP_MAX, OP_MAX, 1, 1, 1, 0);
        table_row(ACT_RED, -1, -1, 0, 0, 1, 1, 1, 0);
        table_row(ACT_RED, OP_MIN, 1, 0, 0, 0, 0, 0, 0);
        table_row(ACT_RED, 0, OP_MIN, 0, 0, 0, 0, 0, 0);
        table_row(ACT_RED, OP_MAX, OP_MIN, 0, 0, 0, 0, 0, 0);
        // consecutive fibonacci numbers: longest remainder chain
        table_row(ACT_RED, 28657, 17711, 0, 0, 0, 0, 0, 0);
        table_row(ACT_RED, 17711, -28657, 0, 0, 0, 0, 0, 0);
        table_row(ACT_RSV5, OP_MAX, OP_MIN, OP_MAX, OP_MIN, 1, 0, 0, 0);
        table_row(ACT_RSV6, -1, -1, -1, -1, 1, 0, 0, 0);
        table_row(ACT_RSV7, OP_MIN, OP_MAX, 1, 1, 1, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].item,
                       directed_rows[i].known ? directed_rows[i].want
                                              : fraction_op(directed_rows[i].item));
        end

        repeat (RAND_ITEMS) begin
            it = random_item();
            offer_item(it, fraction_op(it));
        end
        in_ch.valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // receiver stall pattern, with long hold-offs that back the block up
    initial begin
        int mode, mode_left, hold_left, next_hold_at, cyc;
        bit rdy;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        next_hold_at = 80;
        cyc          = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (results_seen >= next_hold_at) begin
                hold_left    = $urandom_range(200, 300);
                next_hold_at = next_hold_at + 400;
                rdy          = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 1) == 1);
                    2:       rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = (cyc % 3 == 0);
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // result check against the oldest expectation
    initial begin
        t_fraction want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %0d/%0d error %0b", $time,
                             out_ch.res_num, out_ch.res_den, out_ch.error);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.res_num !== want.num) begin
                        $display("%0t: res_num expected %0d got %0d", $time,
                                 want.num, out_ch.res_num);
                        fail_count++;
                    end
                    if (out_ch.res_den !== want.den) begin
                        $display("%0t: res_den expected %0d got %0d", $time,
                                 want.den, out_ch.res_den);
                        fail_count++;
                    end
                    if (out_ch.error !== want.err) begin
                        $display("%0t: error expected %0b got %0b", $time,
                                 want.err, out_ch.error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles where no item moves on either side
    initial begin
        int idle_cyc;
        idle_cyc = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("%0t: nothing moved for %0d cycles, %0d results outstanding", $time,
                         idle_cyc, pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule : rational_arithmetic_unit_test
